// File: design/tqbd_pkg.sv
// Shared types, constants and decode functions of the texture quad block decoder.
`timescale 1ns / 1ps
`default_nettype none
package tqbd_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned InDataW  = 256;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned ColW     = 3;
  localparam int unsigned RowW     = 2;

  typedef struct packed {
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    logic [3:0] a;
  } col5_t;

  typedef struct packed {
    logic [31:0] m0;
    logic [31:0] m1;
    logic [31:0] m2;
    logic [31:0] m3;
    logic        f0;
    logic        f1;
    logic        f2;
    logic        f3;
    col5_t [3:0] ca;
    col5_t [3:0] cb;
    logic        two;
  } item_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            last;
  } pos_t;

  function automatic logic [4:0] wid5(input logic [3:0] v);
    return {v, v[3]};
  endfunction

  function automatic col5_t colour_a(input logic [31:0] c);
    col5_t o;
    if (c[15]) begin
      o.r = c[14:10];
      o.g = c[9:5];
      o.b = wid5(c[4:1]);
      o.a = 4'hf;
    end else begin
      o.r = wid5(c[11:8]);
      o.g = wid5(c[7:4]);
      o.b = {c[3:1], c[3:2]};
      o.a = {c[14:12], 1'b0};
    end
    return o;
  endfunction

  function automatic col5_t colour_b(input logic [31:0] c);
    col5_t o;
    if (c[31]) begin
      o.r = c[30:26];
      o.g = c[25:21];
      o.b = c[20:16];
      o.a = 4'hf;
    end else begin
      o.r = wid5(c[27:24]);
      o.g = wid5(c[23:20]);
      o.b = wid5(c[19:16]);
      o.a = {c[30:28], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [4:0] wt_std(input logic [1:0] code);
    logic [4:0] w;
    case (code)
      2'd0: w = 5'd0;
      2'd1: w = 5'd3;
      2'd2: w = 5'd5;
      default: w = 5'd8;
    endcase
    return w;
  endfunction

  function automatic logic [4:0] wt_punch(input logic [1:0] code);
    logic [4:0] w;
    case (code)
      2'd0: w = 5'd0;
      2'd1: w = 5'd4;
      2'd2: w = 5'h14;
      default: w = 5'd8;
    endcase
    return w;
  endfunction

  // Modulation of one texel of one word; md: 0 direct, 1 HV, 2 H, 3 V.
  function automatic logic [6:0] tex_mod(input logic [31:0] bits_in, input logic flag,
                                         input logic two, input logic [2:0] x,
                                         input logic [1:0] y);
    logic [31:0] bits;
    logic [1:0]  md;
    logic [4:0]  val;
    logic [4:0]  idx;
    logic [3:0]  pidx;
    bits = bits_in;
    md   = 2'd0;
    val  = 5'd0;
    idx  = {y, x};
    pidx = {y, x[2:1]};
    if (two) begin
      if (flag) begin
        md = bits[0] ? (bits[20] ? 2'd3 : 2'd2) : 2'd1;
        if (bits[0]) bits[20] = bits[21];
        bits[0] = bits[1];
        if ((x[0] ^ y[0]) == 1'b0) begin
          md  = 2'd0;
          val = wt_std(bits[{pidx, 1'b0} +: 2]);
        end
      end else begin
        val = bits[idx] ? 5'd8 : 5'd0;
      end
    end else begin
      pidx = {y, x[1:0]};
      val  = flag ? wt_punch(bits[{pidx, 1'b0} +: 2]) : wt_std(bits[{pidx, 1'b0} +: 2]);
    end
    return {md, val};
  endfunction

endpackage
`default_nettype wire

// File: design/tqbd_modgrid.sv
// Modulation fetch for one pixel: unpack the texel and its four neighbors, then interpolate.
`timescale 1ns / 1ps
`default_nettype none
module tqbd_modgrid
  import tqbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire item_t             item,
  input  wire logic [ColW-1:0]   x,
  input  wire logic [RowW-1:0]   y,
  output logic [4:0]             v
);

  logic [4:0] nb_val [5];
  logic [1:0] md_c;
  logic [1:0] md_q;
  logic [4:0] nv_q [5];

  // Texel lookup over the 8x16 window (8x8 in 4bpp); neighbors may lie in adjacent words.
  function automatic logic [6:0] grid(input item_t it, input logic [3:0] gr,
                                      input logic [4:0] gc);
    logic [2:0] lx;
    logic [1:0] ly;
    logic [31:0] m;
    logic f;
    logic [6:0] r;
    if (it.two) begin
      lx = gc[2:0];
    end else begin
      lx = {1'b0, gc[1:0]};
    end
    ly = gr[1:0];
    case ({gr[2], it.two ? gc[3] : gc[2]})
      2'b00: begin m = it.m0; f = it.f0; end
      2'b01: begin m = it.m1; f = it.f1; end
      2'b10: begin m = it.m2; f = it.f2; end
      default: begin m = it.m3; f = it.f3; end
    endcase
    r = tex_mod(m, f, it.two, lx, ly);
    return r;
  endfunction

  always_comb begin
    logic [3:0] gr;
    logic [4:0] gc;
    logic [6:0] t;
    gr = {2'b00, y} + 4'd2;
    gc = {2'b00, x} + (item.two ? 5'd4 : 5'd2);
    t = grid(item, gr, gc);
    md_c = t[6:5];
    nb_val[0] = t[4:0];
    t = grid(item, gr, gc - 5'd1);
    nb_val[1] = t[4:0];
    t = grid(item, gr, gc + 5'd1);
    nb_val[2] = t[4:0];
    t = grid(item, gr - 4'd1, gc);
    nb_val[3] = t[4:0];
    t = grid(item, gr + 4'd1, gc);
    nb_val[4] = t[4:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_q <= item.two ? md_c : 2'd0;
      for (int i = 0; i < 5; i++) nv_q[i] <= nb_val[i];
    end
  end

  always_comb begin
    logic [6:0] s;
    s = '0;
    unique case (md_q)
      2'd0: v = nv_q[0];
      2'd1: begin
        s = {2'b0, nv_q[1]} + {2'b0, nv_q[2]} + {2'b0, nv_q[3]} + {2'b0, nv_q[4]} + 7'd2;
        v = s[6:2];
      end
      2'd2: begin
        s = {2'b0, nv_q[1]} + {2'b0, nv_q[2]} + 7'd1;
        v = s[5:1];
      end
      default: begin
        s = {2'b0, nv_q[3]} + {2'b0, nv_q[4]} + 7'd1;
        v = s[5:1];
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/tqbd_upscale.sv
// Bilinear upscale of one colour channel over the four words; horizontal sums registered.
`timescale 1ns / 1ps
`default_nettype none
module tqbd_upscale
  import tqbd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [4:0]       p,
  input  wire logic [4:0]       q,
  input  wire logic [4:0]       r,
  input  wire logic [4:0]       s,
  input  wire logic             two,
  input  wire logic             is_alpha,
  input  wire logic [ColW-1:0]  x,
  input  wire logic [RowW-1:0]  y,
  output logic [7:0]            o
);

  logic [8:0]  hp;
  logic [8:0]  hr;
  logic [1:0]  y_q;
  logic        two_q;
  logic        alpha_q;
  logic [11:0] sum;

  always_ff @(posedge clk) begin
    logic [3:0] w;
    if (en) begin
      w = two ? 4'd8 : 4'd4;
      hp <= 9'((w - {1'b0, x}) * p + {1'b0, x} * q);
      hr <= 9'((w - {1'b0, x}) * r + {1'b0, x} * s);
      y_q <= y;
      two_q <= two;
      alpha_q <= is_alpha;
    end
  end

  always_comb begin
    sum = 12'((3'd4 - {1'b0, y_q}) * hp + y_q * hr);
    if (alpha_q) begin
      o = two_q ? 8'((sum >> 5) + (sum >> 1)) : 8'((sum >> 4) + sum);
    end else begin
      o = two_q ? 8'((sum >> 7) + (sum >> 2)) : 8'((sum >> 6) + (sum >> 1));
    end
  end

endmodule
`default_nettype wire

// File: design/texture_quad_block_decoder.sv
// Top level of the texture quad block decoder: pixel sequencer, pipeline and output skid.
//
//  channel | dir | beat contents
//  s_axis  | in  | tdata: four modulation/colour word pairs (256 bits)
//  m_axis  | out | tdata: r,g,b,a,col,row (40 bits); tlast on final pixel
//  cfg     | in  | two_bpp_mode, written while idle
//
// One pixel leaves per cycle unless m_axis stalls: 16 pixels per item in 4bpp, 32 in
// 2bpp, set by the pixel sequencer that walks the window. Pixels pass four register
// stages (neighbor fetch/horizontal products, upscale, blend, output register). rst
// clears valids, the sequencer and the mode register. A stall on m_axis freezes the
// pipeline once stage 3 is valid; the next item is taken while the last pixels drain.
`timescale 1ns / 1ps
`default_nettype none
module texture_quad_block_decoder
  import tqbd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tl_mod, tl_col, tr_mod, tr_col, bl_mod, bl_col, br_mod, br_col (low to high)
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // red, green, blue, alpha, pixel_col, pixel_row, zero pad (low to high)
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata
);

  logic two_bpp_mode;
  always_ff @(posedge clk) begin
    if (rst) two_bpp_mode <= 1'b0;
    else if (cfg_we) two_bpp_mode <= cfg_wdata;
  end

  // Stage 0: hold the decoded item while its pixels are issued.
  logic           busy;
  item_t          item;
  logic [ColW-1:0] cx;
  logic [RowW-1:0] cy;
  logic           adv;
  logic           v1, v2, v3;
  logic           out_free;
  logic           last_px;

  assign adv = !v3 || out_free;
  assign last_px = (cy == 2'd3) && (cx == (item.two ? 3'd7 : 3'd3));
  assign s_axis_tready = adv && (!busy || last_px);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cx <= '0;
      cy <= '0;
    end else if (adv) begin
      if (s_axis_tvalid && s_axis_tready) begin
        busy <= 1'b1;
        cx <= '0;
        cy <= '0;
      end else if (busy) begin
        if (last_px) begin
          busy <= 1'b0;
        end else if (cx == (item.two ? 3'd7 : 3'd3)) begin
          cx <= '0;
          cy <= cy + 2'd1;
        end else begin
          cx <= cx + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s_axis_tvalid && s_axis_tready) begin
      item.m0 <= s_axis_tdata[31:0];
      item.m1 <= s_axis_tdata[95:64];
      item.m2 <= s_axis_tdata[159:128];
      item.m3 <= s_axis_tdata[223:192];
      item.f0 <= s_axis_tdata[32];
      item.f1 <= s_axis_tdata[96];
      item.f2 <= s_axis_tdata[160];
      item.f3 <= s_axis_tdata[224];
      item.ca[0] <= colour_a(s_axis_tdata[63:32]);
      item.ca[1] <= colour_a(s_axis_tdata[127:96]);
      item.ca[2] <= colour_a(s_axis_tdata[191:160]);
      item.ca[3] <= colour_a(s_axis_tdata[255:224]);
      item.cb[0] <= colour_b(s_axis_tdata[63:32]);
      item.cb[1] <= colour_b(s_axis_tdata[127:96]);
      item.cb[2] <= colour_b(s_axis_tdata[191:160]);
      item.cb[3] <= colour_b(s_axis_tdata[255:224]);
      item.two <= two_bpp_mode;
    end
  end

  // Stage 1: modulation neighbors and horizontal products registered in units.
  logic [4:0] modv;
  pos_t       pos1, pos2, pos3;
  tqbd_modgrid u_mod (
    .clk(clk), .en(adv), .item(item), .x(cx), .y(cy), .v(modv)
  );

  logic [7:0] ua [4];
  logic [7:0] ub [4];
  for (genvar c = 0; c < 4; c++) begin : g_ch
    logic [4:0] pa, qa, ra, sa, pb, qb, rb, sb;
    always_comb begin
      unique case (c)
        0: begin
          pa = item.ca[0].r; qa = item.ca[1].r; ra = item.ca[2].r; sa = item.ca[3].r;
          pb = item.cb[0].r; qb = item.cb[1].r; rb = item.cb[2].r; sb = item.cb[3].r;
        end
        1: begin
          pa = item.ca[0].g; qa = item.ca[1].g; ra = item.ca[2].g; sa = item.ca[3].g;
          pb = item.cb[0].g; qb = item.cb[1].g; rb = item.cb[2].g; sb = item.cb[3].g;
        end
        2: begin
          pa = item.ca[0].b; qa = item.ca[1].b; ra = item.ca[2].b; sa = item.ca[3].b;
          pb = item.cb[0].b; qb = item.cb[1].b; rb = item.cb[2].b; sb = item.cb[3].b;
        end
        default: begin
          pa = {1'b0, item.ca[0].a}; qa = {1'b0, item.ca[1].a};
          ra = {1'b0, item.ca[2].a}; sa = {1'b0, item.ca[3].a};
          pb = {1'b0, item.cb[0].a}; qb = {1'b0, item.cb[1].a};
          rb = {1'b0, item.cb[2].a}; sb = {1'b0, item.cb[3].a};
        end
      endcase
    end
    tqbd_upscale u_a (
      .clk(clk), .en(adv), .p(pa), .q(qa), .r(ra), .s(sa), .two(item.two),
      .is_alpha(c == 3), .x(cx), .y(cy), .o(ua[c])
    );
    tqbd_upscale u_b (
      .clk(clk), .en(adv), .p(pb), .q(qb), .r(rb), .s(sb), .two(item.two),
      .is_alpha(c == 3), .x(cx), .y(cy), .o(ub[c])
    );
  end

  // Stage 2: register upscaled colours and modulation.
  logic [7:0] a2 [4];
  logic [7:0] b2 [4];
  logic [4:0] m2;
  always_ff @(posedge clk) begin
    if (adv) begin
      pos1 <= '{col: cx, row: cy, last: last_px};
      pos2 <= pos1;
      for (int i = 0; i < 4; i++) begin
        a2[i] <= ua[i];
        b2[i] <= ub[i];
      end
      m2 <= modv;
    end
  end

  // Stage 3: blend; drop alpha of punch-through texels.
  logic [7:0] px3 [4];
  always_ff @(posedge clk) begin
    logic [3:0] m;
    logic [11:0] t;
    if (adv) begin
      m = m2[3:0];
      for (int i = 0; i < 4; i++) begin
        t = 12'(a2[i] * (4'd8 - m) + b2[i] * m);
        px3[i] <= (i == 3 && m2[4]) ? 8'd0 : t[10:3];
      end
      pos3 <= pos2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= busy;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Output register: drop the beat when taken, load a new one when stage 3 advances.
  assign out_free = !m_axis_tvalid || m_axis_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v3) begin
      m_axis_tdata <= {3'b000, pos3.row, pos3.col, px3[3], px3[2], px3[1], px3[0]};
      m_axis_tlast <= pos3.last;
    end
  end

endmodule
`default_nettype wire

// File: design/tqbd_checker.sv
// Port-level checker for the texture quad block decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tqbd_checker
  import tqbd_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic                m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[36:35] == 2'd3 &&
      (m_axis_tdata[34:32] == 3'd3 || m_axis_tdata[34:32] == 3'd7))
    else $error("last beat not at window end");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:37] == 3'b000)
    else $error("pad bits set");

endmodule

bind texture_quad_block_decoder tqbd_checker u_tqbd_checker (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
